### rtl/core/u8tr_pkg.sv
// ============================================================================
// u8tr_pkg
// Shared constants and case mapping for the UTF-8 Turkish case converter.
// ============================================================================
package u8tr_pkg;

    localparam int unsigned CODE_W = 21;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // Register map, as register indexes.
    localparam logic REG_CASE_MODE = 1'b0;

    // Values of the case_mode register.
    localparam logic MODE_UPPER = 1'b0;
    localparam logic MODE_LOWER = 1'b1;

    // Lead byte classes.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;

    // Encoding range limits.
    localparam logic [CODE_W-1:0] LIM_1BYTE = 21'h000080;
    localparam logic [CODE_W-1:0] LIM_2BYTE = 21'h000800;
    localparam logic [CODE_W-1:0] LIM_3BYTE = 21'h010000;

    // Code points with Turkish case rules.
    localparam logic [CODE_W-1:0] CP_CAP_I       = 21'h000049;
    localparam logic [CODE_W-1:0] CP_SMALL_I     = 21'h000069;
    localparam logic [CODE_W-1:0] CP_CAP_I_DOT   = 21'h000130;
    localparam logic [CODE_W-1:0] CP_SMALL_I_DL  = 21'h000131;
    localparam logic [CODE_W-1:0] CP_CAP_C_CED   = 21'h0000C7;
    localparam logic [CODE_W-1:0] CP_SMALL_C_CED = 21'h0000E7;
    localparam logic [CODE_W-1:0] CP_CAP_G_BRV   = 21'h00011E;
    localparam logic [CODE_W-1:0] CP_SMALL_G_BRV = 21'h00011F;
    localparam logic [CODE_W-1:0] CP_CAP_O_UML   = 21'h0000D6;
    localparam logic [CODE_W-1:0] CP_SMALL_O_UML = 21'h0000F6;
    localparam logic [CODE_W-1:0] CP_CAP_S_CED   = 21'h00015E;
    localparam logic [CODE_W-1:0] CP_SMALL_S_CED = 21'h00015F;
    localparam logic [CODE_W-1:0] CP_CAP_U_UML   = 21'h0000DC;
    localparam logic [CODE_W-1:0] CP_SMALL_U_UML = 21'h0000FC;
    localparam logic [CODE_W-1:0] CP_CAP_A       = 21'h000041;
    localparam logic [CODE_W-1:0] CP_CAP_Z       = 21'h00005A;
    localparam logic [CODE_W-1:0] CP_SMALL_A     = 21'h000061;
    localparam logic [CODE_W-1:0] CP_SMALL_Z     = 21'h00007A;

    function automatic logic [CODE_W-1:0] map_upper(input logic [CODE_W-1:0] k);
        logic [CODE_W-1:0] r;
        begin
            r = k;
            if (k == CP_SMALL_I) begin
                r = CP_CAP_I_DOT;
            end else if (k == CP_SMALL_I_DL) begin
                r = CP_CAP_I;
            end else if (k >= CP_SMALL_A && k <= CP_SMALL_Z) begin
                r = {k[CODE_W-1:6], 1'b0, k[4:0]};
            end else if (k == CP_SMALL_C_CED) begin
                r = CP_CAP_C_CED;
            end else if (k == CP_SMALL_G_BRV) begin
                r = CP_CAP_G_BRV;
            end else if (k == CP_SMALL_O_UML) begin
                r = CP_CAP_O_UML;
            end else if (k == CP_SMALL_S_CED) begin
                r = CP_CAP_S_CED;
            end else if (k == CP_SMALL_U_UML) begin
                r = CP_CAP_U_UML;
            end
            return r;
        end
    endfunction

    function automatic logic [CODE_W-1:0] map_lower(input logic [CODE_W-1:0] k);
        logic [CODE_W-1:0] r;
        begin
            r = k;
            if (k == CP_CAP_I) begin
                r = CP_SMALL_I_DL;
            end else if (k == CP_CAP_I_DOT) begin
                r = CP_SMALL_I;
            end else if (k >= CP_CAP_A && k <= CP_CAP_Z) begin
                r = {k[CODE_W-1:6], 1'b1, k[4:0]};
            end else if (k == CP_CAP_C_CED) begin
                r = CP_SMALL_C_CED;
            end else if (k == CP_CAP_G_BRV) begin
                r = CP_SMALL_G_BRV;
            end else if (k == CP_CAP_O_UML) begin
                r = CP_SMALL_O_UML;
            end else if (k == CP_CAP_S_CED) begin
                r = CP_SMALL_S_CED;
            end else if (k == CP_CAP_U_UML) begin
                r = CP_SMALL_U_UML;
            end
            return r;
        end
    endfunction

endpackage

### rtl/core/utf8_turkish_case_converter.sv
// Output: a character's first output beat is valid in the cycle after its last input byte is taken.
// Throughput: one input byte per cycle while results are single beats and the output is ready;
// a character that re-encodes to more than one byte holds the output register; the next byte is
// taken in the cycle its last beat leaves. Bytes inside a sequence give no beats but at text end.
// Reset: synchronous, active low; clears the decoder and case_mode and empties the output register.
// ============================================================================
// utf8_turkish_case_converter
// Decodes UTF-8 bytes, applies Turkish upper or lower case rules and re-encodes.
// ============================================================================
module utf8_turkish_case_converter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input byte channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [u8tr_pkg::BYTE_W-1:0]        i_in_byte,
    input  logic                               i_text_end,
    // Output byte channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [u8tr_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_char_last,
    output logic                               o_text_done,
    output logic                               o_truncated,
    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [u8tr_pkg::APB_AW-1:0]        paddr,
    input  logic [u8tr_pkg::APB_DW-1:0]        pwdata,
    output logic [u8tr_pkg::APB_DW-1:0]        prdata,
    output logic                               pready
);

    localparam int unsigned CW = u8tr_pkg::CODE_W;
    localparam int unsigned BW = u8tr_pkg::BYTE_W;

    // Decoder state: the code point bits gathered so far and the number of
    // continuation bytes still expected.
    logic [CW-1:0]  r_accum, n_accum;
    logic [1:0]     r_remain, n_remain;

    // Output register: up to four encoded bytes, shifted out from entry 0.
    // r_cnt counts the beats still to send; r_end marks that the last of them
    // closes the text, r_trunc that the beat stands for a dropped sequence.
    logic [BW-1:0]  r_buf [4];
    logic [BW-1:0]  n_buf [4];
    logic [2:0]     r_cnt, n_cnt;
    logic           r_end, n_end;
    logic           r_trunc, n_trunc;

    logic           r_case_mode;

    logic           in_beat;
    logic           out_beat;
    logic           cfg_write;
    logic           emit;
    logic           drop;
    logic [CW-1:0]  code;
    logic [CW-1:0]  mapped;
    logic [BW-1:0]  enc [4];
    logic [2:0]     enc_n;

    // ------------------------------------------------------------------
    // Handshakes. A new byte is taken when the output register is empty or
    // its final beat leaves in this cycle, so a character's beats are never
    // overwritten while still pending.
    // ------------------------------------------------------------------
    assign out_beat   = o_out_valid && i_out_ready;
    assign o_in_ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_out_ready);
    assign in_beat    = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Configuration register. Only the case_mode slot is implemented; a
    // write elsewhere in the map is ignored and reads back as zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == u8tr_pkg::REG_CASE_MODE)
                       ? {{(u8tr_pkg::APB_DW-1){1'b0}}, r_case_mode}
                       : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_mode <= u8tr_pkg::MODE_UPPER;
        end else if (cfg_write && paddr[2] == u8tr_pkg::REG_CASE_MODE) begin
            r_case_mode <= pwdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Decode. A lead byte opens a sequence; any byte while one is open is
    // taken as a continuation byte without checking its top bits. ASCII and
    // bytes that are neither complete a character on their own as Latin-1.
    // ------------------------------------------------------------------
    always_comb begin
        n_accum  = r_accum;
        n_remain = r_remain;
        emit     = 1'b0;
        code     = {{(CW-BW){1'b0}}, i_in_byte};
        if (r_remain == 2'd0) begin
            if (i_in_byte[7] == 1'b0) begin
                emit = 1'b1;
            end else if ((i_in_byte & u8tr_pkg::LEAD2_MASK) == u8tr_pkg::LEAD2_VAL) begin
                n_accum  = {{(CW-5){1'b0}}, i_in_byte[4:0]};
                n_remain = 2'd1;
            end else if ((i_in_byte & u8tr_pkg::LEAD3_MASK) == u8tr_pkg::LEAD3_VAL) begin
                n_accum  = {{(CW-4){1'b0}}, i_in_byte[3:0]};
                n_remain = 2'd2;
            end else if ((i_in_byte & u8tr_pkg::LEAD4_MASK) == u8tr_pkg::LEAD4_VAL) begin
                n_accum  = {{(CW-3){1'b0}}, i_in_byte[2:0]};
                n_remain = 2'd3;
            end else begin
                emit = 1'b1;
            end
        end else begin
            code     = {r_accum[CW-7:0], i_in_byte[5:0]};
            n_remain = r_remain - 2'd1;
            n_accum  = code;
            if (r_remain == 2'd1) begin
                emit    = 1'b1;
                n_accum = '0;
            end
        end
        // A sequence still open after the final byte of the text is dropped.
        drop = !emit && i_text_end;
        if (drop) begin
            n_accum  = '0;
            n_remain = 2'd0;
        end
    end

    // Case mapping and shortest-form re-encoding.
    assign mapped = (r_case_mode == u8tr_pkg::MODE_LOWER) ? u8tr_pkg::map_lower(code)
                                                          : u8tr_pkg::map_upper(code);

    always_comb begin
        enc[0] = '0;
        enc[1] = '0;
        enc[2] = '0;
        enc[3] = '0;
        if (mapped < u8tr_pkg::LIM_1BYTE) begin
            enc[0] = mapped[7:0];
            enc_n  = 3'd1;
        end else if (mapped < u8tr_pkg::LIM_2BYTE) begin
            enc[0] = {3'b110, mapped[10:6]};
            enc[1] = {2'b10, mapped[5:0]};
            enc_n  = 3'd2;
        end else if (mapped < u8tr_pkg::LIM_3BYTE) begin
            enc[0] = {4'b1110, mapped[15:12]};
            enc[1] = {2'b10, mapped[11:6]};
            enc[2] = {2'b10, mapped[5:0]};
            enc_n  = 3'd3;
        end else begin
            enc[0] = {5'b11110, mapped[20:18]};
            enc[1] = {2'b10, mapped[17:12]};
            enc[2] = {2'b10, mapped[11:6]};
            enc[3] = {2'b10, mapped[5:0]};
            enc_n  = 3'd4;
        end
    end

    // ------------------------------------------------------------------
    // Output register. Each delivered beat shifts the pending bytes down;
    // an accepted byte that yields results loads the register afresh.
    // ------------------------------------------------------------------
    always_comb begin
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_end   = r_end;
        n_trunc = r_trunc;
        if (out_beat) begin
            n_buf[0] = r_buf[1];
            n_buf[1] = r_buf[2];
            n_buf[2] = r_buf[3];
            n_cnt    = r_cnt - 3'd1;
        end
        if (in_beat && emit) begin
            n_buf   = enc;
            n_cnt   = enc_n;
            n_end   = i_text_end;
            n_trunc = 1'b0;
        end else if (in_beat && drop) begin
            n_buf[0] = '0;
            n_cnt    = 3'd1;
            n_end    = 1'b1;
            n_trunc  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum  <= '0;
            r_remain <= 2'd0;
            r_cnt    <= 3'd0;
            r_end    <= 1'b0;
            r_trunc  <= 1'b0;
        end else begin
            if (in_beat) begin
                r_accum  <= n_accum;
                r_remain <= n_remain;
            end
            r_cnt   <= n_cnt;
            r_end   <= n_end;
            r_trunc <= n_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_byte  = r_buf[0];
    assign o_char_last = (r_cnt == 3'd1) && !r_trunc;
    assign o_text_done = (r_cnt == 3'd1) && r_end;
    assign o_truncated = r_trunc;

`ifndef ASSERT_OFF
    // No byte is taken while more than one beat of a character is pending.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 3'd1) |-> !o_in_ready)
        else $error("input accepted while output beats pending");

    // The final byte of the text always leaves the decoder idle.
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && i_text_end) |=> (r_remain == 2'd0))
        else $error("sequence left open after text end");

    // With no sequence open, the accumulator holds nothing.
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_remain == 2'd0) |-> (r_accum == '0))
        else $error("stale code bits while decoder idle");

    // A truncation beat is a single beat that closes the text.
    a_trunc_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_truncated) |-> (o_text_done && !o_char_last && r_cnt == 3'd1))
        else $error("malformed truncation beat");
`endif

endmodule

### dv/tb_utf8_turkish_case_converter.sv
// ----------------------------------------------------------------------------
// Testbench for the UTF-8 Turkish case converter
// Streams UTF-8 text through the converter under both case modes, predicts
// every output beat with a local decoder, case folder and encoder, and checks
// the output channel beat by beat while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_utf8_turkish_case_converter;

    localparam int unsigned CODE_W = u8tr_pkg::CODE_W;
    localparam int unsigned BYTE_W = u8tr_pkg::BYTE_W;
    localparam int unsigned APB_AW = u8tr_pkg::APB_AW;
    localparam int unsigned APB_DW = u8tr_pkg::APB_DW;

    // Address of the case_mode register, and of an unmapped register slot.
    localparam int unsigned IDX_SPARE = 1;
    localparam logic [APB_AW-1:0] ADDR_CASE_MODE = APB_AW'(4 * u8tr_pkg::REG_CASE_MODE);
    localparam logic [APB_AW-1:0] ADDR_SPARE     = APB_AW'(4 * IDX_SPARE);

    // The output register is the only state that holds beats, so the quiet spell counted by
    // SETTLE_CYCLES is plenty to call the block idle.
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 120;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int TEXT_BYTES    = 260;
    localparam int MAX_REPORTS   = 10;

    // What the stimulus queue can hold: a text byte, a register write, or a
    // pause that lasts until every expected beat has been seen.
    typedef enum logic [1:0] {
        ITEM_BYTE,
        ITEM_WRITE,
        ITEM_SYNC
    } t_item_kind;

    typedef struct {
        t_item_kind        kind;
        logic [BYTE_W-1:0] data;
        logic              text_end;
        int                gap;
        logic [APB_AW-1:0] addr;
        logic [APB_DW-1:0] wdata;
    } t_text_item;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              char_last;
        logic              text_done;
        logic              truncated;
    } t_out_beat;

    typedef enum logic [2:0] {
        DRV_LOAD,
        DRV_GAP,
        DRV_OFFER,
        DRV_SETUP,
        DRV_ACCESS,
        DRV_SYNC
    } t_drv_state;

    // ------------------------------------------------------------------------
    // Clock, reset and the converter itself.
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #1 i_clk = ~i_clk;

    logic              i_in_valid  = 1'b0;
    logic [BYTE_W-1:0] i_in_byte   = '0;
    logic              i_text_end  = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_char_last;
    logic              o_text_done;
    logic              o_truncated;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    utf8_turkish_case_converter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_text_end  (i_text_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_char_last (o_char_last),
        .o_text_done (o_text_done),
        .o_truncated (o_truncated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // ------------------------------------------------------------------------
    // Shared state between stimulus, driver and monitor.
    // ------------------------------------------------------------------------
    t_text_item        text_queue[$];   // items still to be sent
    t_out_beat         exp_beats[$];    // output beats predicted, oldest first
    logic [BYTE_W-1:0] txt_buf[$];      // one text being assembled
    int                gap_style = 0;   // how the sender idles in this stretch
    int                err_cnt   = 0;
    int                cycle_cnt = 0;

    // Decoder and register state as the converter should hold them.
    logic              mode_model = u8tr_pkg::MODE_UPPER;
    logic [CODE_W-1:0] seq_code   = '0;
    logic [1:0]        seq_left   = '0;

    // ------------------------------------------------------------------------
    // Prediction.
    // ------------------------------------------------------------------------

    // Turkish case folding: dotted i pairs up with the dotted capital I and dotless
    // i with I, ASCII letters shift by 32, and the five accented letters swap
    // between their small and capital code points.
    function automatic logic [CODE_W-1:0] fold_case_tr(input logic [CODE_W-1:0] k,
                                                       input logic mode);
        logic [CODE_W-1:0] r;
        r = k;
        if (mode == u8tr_pkg::MODE_UPPER) begin
            case (k)
                u8tr_pkg::CP_SMALL_I:     r = u8tr_pkg::CP_CAP_I_DOT;
                u8tr_pkg::CP_SMALL_I_DL:  r = u8tr_pkg::CP_CAP_I;
                u8tr_pkg::CP_SMALL_C_CED: r = u8tr_pkg::CP_CAP_C_CED;
                u8tr_pkg::CP_SMALL_G_BRV: r = u8tr_pkg::CP_CAP_G_BRV;
                u8tr_pkg::CP_SMALL_O_UML: r = u8tr_pkg::CP_CAP_O_UML;
                u8tr_pkg::CP_SMALL_S_CED: r = u8tr_pkg::CP_CAP_S_CED;
                u8tr_pkg::CP_SMALL_U_UML: r = u8tr_pkg::CP_CAP_U_UML;
                default: begin
                    if (k >= u8tr_pkg::CP_SMALL_A && k <= u8tr_pkg::CP_SMALL_Z)
                        r = k - CODE_W'(32);
                end
            endcase
        end else begin
            case (k)
                u8tr_pkg::CP_CAP_I:     r = u8tr_pkg::CP_SMALL_I_DL;
                u8tr_pkg::CP_CAP_I_DOT: r = u8tr_pkg::CP_SMALL_I;
                u8tr_pkg::CP_CAP_C_CED: r = u8tr_pkg::CP_SMALL_C_CED;
                u8tr_pkg::CP_CAP_G_BRV: r = u8tr_pkg::CP_SMALL_G_BRV;
                u8tr_pkg::CP_CAP_O_UML: r = u8tr_pkg::CP_SMALL_O_UML;
                u8tr_pkg::CP_CAP_S_CED: r = u8tr_pkg::CP_SMALL_S_CED;
                u8tr_pkg::CP_CAP_U_UML: r = u8tr_pkg::CP_SMALL_U_UML;
                default: begin
                    if (k >= u8tr_pkg::CP_CAP_A && k <= u8tr_pkg::CP_CAP_Z)
                        r = k + CODE_W'(32);
                end
            endcase
        end
        return r;
    endfunction

    // Shortest UTF-8 form of a code point; byte i sits at enc[8*i +: 8].
    // Anything at or above 0x10000 takes four bytes, up to the full 21 bits.
    function automatic int utf8_encode(input logic [CODE_W-1:0] k,
                                       output logic [31:0] enc);
        int n;
        enc = '0;
        if (k < u8tr_pkg::LIM_1BYTE) begin
            enc[7:0] = k[7:0];
            n = 1;
        end else if (k < u8tr_pkg::LIM_2BYTE) begin
            enc[7:0]  = {3'b110, k[10:6]};
            enc[15:8] = {2'b10, k[5:0]};
            n = 2;
        end else if (k < u8tr_pkg::LIM_3BYTE) begin
            enc[7:0]   = {4'b1110, k[15:12]};
            enc[15:8]  = {2'b10, k[11:6]};
            enc[23:16] = {2'b10, k[5:0]};
            n = 3;
        end else begin
            enc[7:0]   = {5'b11110, k[20:18]};
            enc[15:8]  = {2'b10, k[17:12]};
            enc[23:16] = {2'b10, k[11:6]};
            enc[31:24] = {2'b10, k[5:0]};
            n = 4;
        end
        return n;
    endfunction

    // Queue the beats of one converted character.
    task automatic expect_char(input logic [CODE_W-1:0] code, input logic text_last);
        logic [31:0] enc;
        int          n;
        int          i;
        n = utf8_encode(fold_case_tr(code, mode_model), enc);
        for (i = 0; i < n; i++) begin
            exp_beats.push_back('{data:      enc[8*i +: 8],
                                  char_last: (i == n - 1),
                                  text_done: (i == n - 1) && text_last,
                                  truncated: 1'b0});
        end
    endtask

    // Step the decoder by one accepted byte. Following bytes are never
    // checked: only their low six bits count. A byte that cannot start a
    // sequence stands alone as a Latin-1 code point.
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic text_last);
        logic open_seq;
        open_seq = 1'b0;
        if (seq_left == 2'd0) begin
            if (b < 8'h80) begin
                expect_char(CODE_W'(b), text_last);
            end else if ((b & u8tr_pkg::LEAD2_MASK) == u8tr_pkg::LEAD2_VAL) begin
                seq_code = CODE_W'(b[4:0]);
                seq_left = 2'd1;
                open_seq = 1'b1;
            end else if ((b & u8tr_pkg::LEAD3_MASK) == u8tr_pkg::LEAD3_VAL) begin
                seq_code = CODE_W'(b[3:0]);
                seq_left = 2'd2;
                open_seq = 1'b1;
            end else if ((b & u8tr_pkg::LEAD4_MASK) == u8tr_pkg::LEAD4_VAL) begin
                seq_code = CODE_W'(b[2:0]);
                seq_left = 2'd3;
                open_seq = 1'b1;
            end else begin
                expect_char(CODE_W'(b), text_last);
            end
        end else begin
            seq_code = {seq_code[CODE_W-7:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
                expect_char(seq_code, text_last);
                seq_code = '0;
            end else begin
                open_seq = 1'b1;
            end
        end
        // A sequence still open when the text ends is dropped, and a single
        // truncated marker beat takes its place.
        if (open_seq && text_last) begin
            seq_code = '0;
            seq_left = 2'd0;
            exp_beats.push_back('{data: '0, char_last: 1'b0, text_done: 1'b1,
                                  truncated: 1'b1});
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building.
    // ------------------------------------------------------------------------

    // The sender's idle time before each byte depends on the current style:
    // none at all, a random gap before every byte, or an occasional gap.
    task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic text_last);
        int gap;
        case (gap_style)
            0:       gap = 0;
            1:       gap = $urandom_range(0, 10);
            default: gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
        endcase
        text_queue.push_back('{kind: ITEM_BYTE, data: b, text_end: text_last, gap: gap,
                               addr: '0, wdata: '0});
    endtask

    task automatic queue_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        text_queue.push_back('{kind: ITEM_WRITE, data: '0, text_end: 1'b0, gap: 0,
                               addr: addr, wdata: data});
    endtask

    task automatic queue_sync();
        text_queue.push_back('{kind: ITEM_SYNC, data: '0, text_end: 1'b0, gap: 0,
                               addr: '0, wdata: '0});
    endtask

    // Send the assembled text, marking its final byte as the end of text.
    task automatic flush_text();
        int i;
        for (i = 0; i < txt_buf.size(); i++) begin
            queue_byte(txt_buf[i], i == txt_buf.size() - 1);
        end
        txt_buf.delete();
    endtask

    task automatic put_code(input logic [CODE_W-1:0] code);
        logic [31:0] enc;
        int          n;
        int          i;
        n = utf8_encode(code, enc);
        for (i = 0; i < n; i++) txt_buf.push_back(enc[8*i +: 8]);
    endtask

    // A lead byte for a sequence of len bytes with random payload bits, then
    // a number of following bytes. Loose following bytes take any value.
    task automatic put_lead_seq(input int len, input int follow, input bit loose);
        logic [7:0] r;
        int         i;
        r = 8'($urandom);
        case (len)
            2:       txt_buf.push_back({3'b110, r[4:0]});
            3:       txt_buf.push_back({4'b1110, r[3:0]});
            default: txt_buf.push_back({5'b11110, r[2:0]});
        endcase
        for (i = 0; i < follow; i++) begin
            r = 8'($urandom);
            txt_buf.push_back(loose ? r : {2'b10, r[5:0]});
        end
    endtask

    // One random character, weighted toward the letters with case rules.
    task automatic put_random_char();
        int sel;
        int len;
        sel = $urandom_range(0, 99);
        if (sel < 28) begin
            txt_buf.push_back(8'($urandom_range(0, 127)));
        end else if (sel < 55) begin
            case ($urandom_range(0, 15))
                0:  put_code(u8tr_pkg::CP_SMALL_I);
                1:  put_code(u8tr_pkg::CP_CAP_I);
                2:  put_code(u8tr_pkg::CP_SMALL_I_DL);
                3:  put_code(u8tr_pkg::CP_CAP_I_DOT);
                4:  put_code(u8tr_pkg::CP_SMALL_C_CED);
                5:  put_code(u8tr_pkg::CP_CAP_C_CED);
                6:  put_code(u8tr_pkg::CP_SMALL_G_BRV);
                7:  put_code(u8tr_pkg::CP_CAP_G_BRV);
                8:  put_code(u8tr_pkg::CP_SMALL_O_UML);
                9:  put_code(u8tr_pkg::CP_CAP_O_UML);
                10: put_code(u8tr_pkg::CP_SMALL_S_CED);
                11: put_code(u8tr_pkg::CP_CAP_S_CED);
                12: put_code(u8tr_pkg::CP_SMALL_U_UML);
                13: put_code(u8tr_pkg::CP_CAP_U_UML);
                14: put_code(u8tr_pkg::CP_SMALL_A + CODE_W'($urandom_range(0, 25)));
                default: put_code(u8tr_pkg::CP_CAP_A + CODE_W'($urandom_range(0, 25)));
            endcase
        end else if (sel < 67) begin
            put_code(CODE_W'($urandom_range(32'h80, 32'h7FF)));
        end else if (sel < 76) begin
            put_code(CODE_W'($urandom_range(32'h800, 32'hFFFF)));
        end else if (sel < 83) begin
            put_code(CODE_W'($urandom_range(32'h10000, 32'h1FFFFF)));
        end else if (sel < 91) begin
            // Stray bytes: a lone following byte, or one of 0xF8..0xFF.
            if ($urandom_range(0, 1) == 0) txt_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
            else txt_buf.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        end else begin
            // Lead byte with unchecked following bytes; overlong forms land
            // here as well.
            len = $urandom_range(2, 4);
            put_lead_seq(len, len - 1, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. Works through text_queue one item at a time: text bytes go out
    // on the input channel after their idle gap, register writes go through
    // a setup and an access cycle, and a sync item holds everything back until
    // all expected beats have arrived and the block has had time to settle.
    // Each driven signal is assigned exactly once per edge from next-values.
    // ------------------------------------------------------------------------
    t_drv_state        drv_state   = DRV_LOAD;
    int                gap_left    = 0;
    int                settle_left = 0;
    logic              nxt_valid;
    logic [BYTE_W-1:0] nxt_byte;
    logic              nxt_end;
    logic              nxt_psel;
    logic              nxt_pen;
    logic [APB_AW-1:0] nxt_addr;
    logic [APB_DW-1:0] nxt_wdata;

    always @(posedge i_clk) begin
        nxt_valid = i_in_valid;
        nxt_byte  = i_in_byte;
        nxt_end   = i_text_end;
        nxt_psel  = psel;
        nxt_pen   = penable;
        nxt_addr  = paddr;
        nxt_wdata = pwdata;
        if (!i_rst_n) begin
            drv_state = DRV_LOAD;
            nxt_valid = 1'b0;
            nxt_psel  = 1'b0;
            nxt_pen   = 1'b0;
        end else begin
            case (drv_state)
                DRV_OFFER: begin
                    // The beat is taken at this edge, so it is predicted now,
                    // with the case mode in force at this moment.
                    if (i_in_valid && o_in_ready) begin
                        decode_byte(i_in_byte, i_text_end);
                        text_queue.delete(0);
                        nxt_valid = 1'b0;
                        drv_state = DRV_LOAD;
                    end
                end
                DRV_GAP: begin
                    if (gap_left == 0) begin
                        nxt_valid = 1'b1;
                        nxt_byte  = text_queue[0].data;
                        nxt_end   = text_queue[0].text_end;
                        drv_state = DRV_OFFER;
                    end else begin
                        gap_left--;
                    end
                end
                DRV_SETUP: begin
                    nxt_pen   = 1'b1;
                    drv_state = DRV_ACCESS;
                end
                DRV_ACCESS: begin
                    // The register takes the value at this edge. Writes to
                    // any slot other than case_mode must change nothing.
                    if (pready) begin
                        if (paddr == ADDR_CASE_MODE) mode_model = pwdata[0];
                        nxt_psel  = 1'b0;
                        nxt_pen   = 1'b0;
                        text_queue.delete(0);
                        drv_state = DRV_LOAD;
                    end
                end
                DRV_SYNC: begin
                    if (exp_beats.size() == 0) begin
                        if (settle_left == 0) begin
                            text_queue.delete(0);
                            drv_state = DRV_LOAD;
                        end else begin
                            settle_left--;
                        end
                    end
                end
                default: ;
            endcase

            // Pick up the next item in the same cycle, so that back-to-back
            // beats keep valid high without a bubble.
            if (drv_state == DRV_LOAD && text_queue.size() != 0) begin
                case (text_queue[0].kind)
                    ITEM_BYTE: begin
                        if (text_queue[0].gap == 0) begin
                            nxt_valid = 1'b1;
                            nxt_byte  = text_queue[0].data;
                            nxt_end   = text_queue[0].text_end;
                            drv_state = DRV_OFFER;
                        end else begin
                            gap_left  = text_queue[0].gap - 1;
                            drv_state = DRV_GAP;
                        end
                    end
                    ITEM_WRITE: begin
                        nxt_psel  = 1'b1;
                        nxt_pen   = 1'b0;
                        nxt_addr  = text_queue[0].addr;
                        nxt_wdata = text_queue[0].wdata;
                        drv_state = DRV_SETUP;
                    end
                    default: begin
                        settle_left = SETTLE_CYCLES;
                        drv_state   = DRV_SYNC;
                    end
                endcase
            end
        end
        i_in_valid <= nxt_valid;
        i_in_byte  <= nxt_byte;
        i_text_end <= nxt_end;
        psel       <= nxt_psel;
        penable    <= nxt_pen;
        pwrite     <= nxt_psel;
        paddr      <= nxt_addr;
        pwdata     <= nxt_wdata;
    end

    // ------------------------------------------------------------------------
    // Receiver and monitor. After every beat the receiver draws how long it
    // stays away; its style changes every 32 beats so that stretches of full
    // rate alternate with heavy stalling. Twice in the run it holds off for a
    // long stretch, long enough for the converter to back up to its input.
    // ------------------------------------------------------------------------
    int        rx_beats   = 0;
    int        rx_style   = 0;
    int        stall_left = 0;
    int        stall_draw;
    logic      nxt_ready;
    t_out_beat got_beat;
    t_out_beat want_beat;

    always @(posedge i_clk) begin
        nxt_ready = i_out_ready;
        if (!i_rst_n) begin
            nxt_ready  = 1'b0;
            stall_left = 0;
        end else if (o_out_valid && i_out_ready) begin
            got_beat = '{data: o_out_byte, char_last: o_char_last,
                         text_done: o_text_done, truncated: o_truncated};
            if (exp_beats.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected beat: byte %02h last %0b done %0b trunc %0b",
                             got_beat.data, got_beat.char_last, got_beat.text_done,
                             got_beat.truncated);
            end else begin
                want_beat = exp_beats.pop_front();
                if (got_beat !== want_beat) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display({"beat mismatch: expected byte %02h last %0b done %0b ",
                                  "trunc %0b, got byte %02h last %0b done %0b trunc %0b"},
                                 want_beat.data, want_beat.char_last, want_beat.text_done,
                                 want_beat.truncated, got_beat.data, got_beat.char_last,
                                 got_beat.text_done, got_beat.truncated);
                end
            end

            rx_beats++;
            if (rx_beats % 32 == 0) rx_style = $urandom_range(0, 2);
            if (rx_beats == 60 || rx_beats == 300) begin
                stall_draw = LONG_HOLD;
            end else begin
                case (rx_style)
                    0:       stall_draw = 0;
                    1:       stall_draw = $urandom_range(0, 10);
                    default: stall_draw = ($urandom_range(0, 3) == 0) ?
                                          $urandom_range(1, 10) : 0;
                endcase
            end
            if (stall_draw == 0) begin
                nxt_ready = 1'b1;
            end else begin
                nxt_ready  = 1'b0;
                stall_left = stall_draw - 1;
            end
        end else if (!i_out_ready) begin
            if (stall_left == 0) nxt_ready = 1'b1;
            else stall_left--;
        end
        i_out_ready <= nxt_ready;
    end

    // A run that hangs is a failure.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence. The whole stimulus is queued at time zero; the driver
    // consumes it once reset is released.
    // ------------------------------------------------------------------------
    int          rand_bytes;
    int          tail_len;
    logic        mode_pick;
    logic [31:0] mode_word;

    initial begin
        // Directed text in the reset mode (upper case): i, dotless i, z, small
        // c-cedilla, g-breve and s-cedilla, the byte 0xFF on its own, the largest
        // 21-bit value in four bytes, an ASCII-looking byte taken as a
        // following byte, and a three-byte sequence cut off by the text end.
        gap_style = 0;
        txt_buf = '{8'h69, 8'hC4, 8'hB1, 8'h7A, 8'hC3, 8'hA7, 8'hC4, 8'h9F,
                    8'hC5, 8'h9F, 8'hFF, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                    8'hC4, 8'h41, 8'hE2, 8'h82};
        flush_text();

        // Lower case with every data bit set; then a write to the unmapped
        // slot, which must leave the mode alone.
        queue_sync();
        queue_write(ADDR_CASE_MODE, 32'hFFFF_FFFF);
        queue_write(ADDR_SPARE, 32'h0000_0000);

        // Directed text in lower case: I, dotted capital I, A, NUL, capital
        // o-umlaut and u-umlaut, an overlong two-byte form of 0x01, and a
        // four-byte lead byte that is the last byte of the text.
        gap_style = 1;
        txt_buf = '{8'h49, 8'hC4, 8'hB0, 8'h41, 8'h00, 8'hC3, 8'h96, 8'hC3, 8'h9C,
                    8'hC0, 8'h81, 8'hF0};
        flush_text();

        // Random texts. Half of them start with a pause and a fresh mode
        // write; some end in an unfinished sequence.
        rand_bytes = 0;
        while (rand_bytes < TEXT_BYTES) begin
            if ($urandom_range(0, 1) == 0) begin
                queue_sync();
                mode_pick = 1'($urandom_range(0, 1));
                mode_word = $urandom;
                queue_write(ADDR_CASE_MODE, {mode_word[31:1], mode_pick});
                if ($urandom_range(0, 7) == 0) queue_write(ADDR_SPARE, $urandom);
                gap_style = $urandom_range(0, 2);
            end
            repeat ($urandom_range(1, 12)) put_random_char();
            if ($urandom_range(0, 7) == 0) begin
                // A lead byte followed by fewer following bytes than it
                // calls for, so the text ends inside the sequence.
                tail_len = $urandom_range(2, 4);
                put_lead_seq(tail_len, $urandom_range(0, tail_len - 2), 1'b0);
            end
            rand_bytes += txt_buf.size();
            flush_text();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_queue.size() != 0 || exp_beats.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
